// ----- src/ilist_pkg.sv -----
// Shared types, codes and widths for the indexed insert/erase list.
package ilist_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int WORD_W    = 32;
  localparam int POS_W     = 5;
  localparam int FILL_W    = 5;
  localparam int OP_W      = 2;
  localparam int ST_W      = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_INSERT = 2'd2,
    OP_ERASE  = 2'd3
  } ilist_op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } ilist_status_t;

  // Broadcast to every cell; op flags are set only for a request that succeeds.
  typedef struct packed {
    logic go;
    logic push;
    logic pop;
    logic ins;
    logic era;
  } ilist_cmd_t;

endpackage

// ----- src/ilist_req_if.sv -----
// Request channel: operation, position and word with valid/ready.
interface ilist_req_if;
  logic                                     valid;
  logic                                     ready;
  logic [ilist_pkg::OP_W-1:0]               operation;
  logic [ilist_pkg::POS_W-1:0]              position;
  logic signed [ilist_pkg::WORD_W-1:0]      word_in;

  modport source (output valid, operation, position, word_in, input ready);
  modport sink   (input valid, operation, position, word_in, output ready);
endinterface

// ----- src/ilist_rsp_if.sv -----
// Result channel: removed word, fill count and status with valid/ready.
interface ilist_rsp_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [ilist_pkg::WORD_W-1:0]      word_out;
  logic [ilist_pkg::FILL_W-1:0]             fill_count;
  logic [ilist_pkg::ST_W-1:0]               status;

  modport source (output valid, word_out, fill_count, status, input ready);
  modport sink   (input valid, word_out, fill_count, status, output ready);
endinterface

// ----- src/indexed_insert_erase_list.sv -----
// Top level: bounded ordered list built as a chain of slot cells.
//
//   channel | dir | handshake           | payload
//   --------+-----+---------------------+-------------------------------------
//   in_ch   | in  | valid/ready         | operation, position, word_in
//   out_ch  | out | valid/ready         | word_out, fill_count, status
//
// For each request, the accept edge updates every cell at once
// (shift up, shift down, load or hold) and latches the removed word in its
// cell; the next edge ORs the cell taps into the output register.
// One request is in flight at a time; a new one is taken in the cycle its
// predecessor's result is taken. Output stalls hold the result register.
// Synchronous active-low reset clears the count and handshake state; slot
// contents are not reset and are only read below the count.
module indexed_insert_erase_list #(
  parameter int DEPTH = ilist_pkg::DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  ilist_req_if.sink    in_ch,
  ilist_rsp_if.source  out_ch
);

  localparam int CW   = $clog2(DEPTH+1);
  localparam int CMPW = ((CW > ilist_pkg::POS_W) ? CW : ilist_pkg::POS_W) + 1;

  // handshake / pipeline control
  logic                          pend_r;        // cells updated, taps awaiting collection
  logic                          out_valid_r;
  logic                          fire;

  // list state
  logic [CW-1:0]                 count_r, count_nxt;

  // result registers
  ilist_pkg::ilist_status_t      pend_status_r, status_nxt;
  logic [ilist_pkg::WORD_W-1:0]  out_word_r;
  logic [ilist_pkg::FILL_W-1:0]  out_fill_r;
  ilist_pkg::ilist_status_t      out_status_r;

  ilist_pkg::ilist_op_t          op;
  ilist_pkg::ilist_cmd_t         cmd;
  logic [CMPW-1:0]               pos_x, cnt_x, dep_x;

  // chain wiring
  logic [ilist_pkg::WORD_W-1:0]  cell_word [DEPTH];
  logic [ilist_pkg::WORD_W-1:0]  cell_tap  [DEPTH];
  logic [ilist_pkg::WORD_W-1:0]  tap_or;

  // no request is taken while reset is held
  assign in_ch.ready = rst_n && !pend_r && (!out_valid_r || out_ch.ready);
  assign fire        = in_ch.valid && in_ch.ready;

  assign op    = ilist_pkg::ilist_op_t'(in_ch.operation);
  assign pos_x = CMPW'(in_ch.position);
  assign cnt_x = CMPW'(count_r);
  assign dep_x = CMPW'(DEPTH);

  // Decide the outcome; the index check on insert comes before the full check.
  always_comb begin
    status_nxt = ilist_pkg::ST_OK;
    count_nxt  = count_r;
    unique case (op)
      ilist_pkg::OP_PUSH: begin
        if (cnt_x >= dep_x) status_nxt = ilist_pkg::ST_FULL;
        else                count_nxt  = count_r + CW'(1);
      end
      ilist_pkg::OP_POP: begin
        if (count_r == '0) status_nxt = ilist_pkg::ST_EMPTY;
        else               count_nxt  = count_r - CW'(1);
      end
      ilist_pkg::OP_INSERT: begin
        if (pos_x > cnt_x)       status_nxt = ilist_pkg::ST_RANGE;
        else if (cnt_x >= dep_x) status_nxt = ilist_pkg::ST_FULL;
        else                     count_nxt  = count_r + CW'(1);
      end
      ilist_pkg::OP_ERASE: begin
        if (pos_x >= cnt_x) status_nxt = ilist_pkg::ST_RANGE;
        else                count_nxt  = count_r - CW'(1);
      end
      default: begin
        status_nxt = ilist_pkg::ST_OK;
      end
    endcase
  end

  // Broadcast command; a failed request only clears the taps.
  always_comb begin
    cmd      = '0;
    cmd.go   = fire;
    if (fire && (status_nxt == ilist_pkg::ST_OK)) begin
      cmd.push = (op == ilist_pkg::OP_PUSH);
      cmd.pop  = (op == ilist_pkg::OP_POP);
      cmd.ins  = (op == ilist_pkg::OP_INSERT);
      cmd.era  = (op == ilist_pkg::OP_ERASE);
    end
  end

  // Row of cells; left of cell i is cell i-1 or word_in, right is cell i+1 or zero.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ilist_pkg::WORD_W-1:0] left_w, right_w;
    if (i == 0) begin : g_first
      assign left_w = in_ch.word_in;
    end else begin : g_mid_l
      assign left_w = cell_word[i-1];
    end
    if (i == DEPTH-1) begin : g_last
      assign right_w = '0;
    end else begin : g_mid_r
      assign right_w = cell_word[i+1];
    end
    ilist_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk     (clk),
      .cmd     (cmd),
      .count   (count_r),
      .pos     (in_ch.position),
      .word_in (in_ch.word_in),
      .left    (left_w),
      .right   (right_w),
      .word    (cell_word[i]),
      .tap     (cell_tap[i])
    );
  end

  // At most one tap is nonzero: collect the removed word.
  always_comb begin
    tap_or = '0;
    for (int k = 0; k < DEPTH; k++) begin
      tap_or = tap_or | cell_tap[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      if (fire) begin
        count_r       <= count_nxt;
        pend_status_r <= status_nxt;
      end
      if (pend_r) begin
        out_word_r   <= tap_or;
        out_fill_r   <= ilist_pkg::FILL_W'(count_r);
        out_status_r <= pend_status_r;
        out_valid_r  <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r  <= 1'b0;
      end
      pend_r <= fire;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.word_out   = out_word_r;
  assign out_ch.fill_count = out_fill_r;
  assign out_ch.status     = out_status_r;

endmodule

// ----- src/ilist_cell.sv -----
// One list slot: holds a word, loads, shifts from a neighbor or taps it out.
module ilist_cell #(
  parameter int DEPTH = ilist_pkg::DEPTH_DEF,
  parameter int IDX   = 0
) (
  input  logic                              clk,
  input  ilist_pkg::ilist_cmd_t             cmd,
  input  logic [$clog2(DEPTH+1)-1:0]        count,
  input  logic [ilist_pkg::POS_W-1:0]       pos,
  input  logic [ilist_pkg::WORD_W-1:0]      word_in,
  input  logic [ilist_pkg::WORD_W-1:0]      left,
  input  logic [ilist_pkg::WORD_W-1:0]      right,
  output logic [ilist_pkg::WORD_W-1:0]      word,
  output logic [ilist_pkg::WORD_W-1:0]      tap
);

  localparam int CW   = $clog2(DEPTH+1);
  localparam int CMPW = ((CW > ilist_pkg::POS_W) ? CW : ilist_pkg::POS_W) + 1;

  logic [ilist_pkg::WORD_W-1:0] word_r, word_nxt;
  logic [ilist_pkg::WORD_W-1:0] tap_r;
  logic [CMPW-1:0]              idx, c, p;
  logic                         sel;

  assign idx = CMPW'(IDX);
  assign c   = CMPW'(count);
  assign p   = CMPW'(pos);

  always_comb begin
    word_nxt = word_r;
    sel      = 1'b0;
    if (cmd.push && (idx == c)) begin
      word_nxt = word_in;
    end
    if (cmd.pop && (idx == c - CMPW'(1))) begin
      sel = 1'b1;
    end
    if (cmd.ins) begin
      if (idx == p) begin
        word_nxt = word_in;
      end else if ((idx > p) && (idx <= c)) begin
        word_nxt = left;
      end
    end
    if (cmd.era) begin
      if (idx == p) begin
        sel = 1'b1;
      end
      if ((idx >= p) && (idx + CMPW'(1) < c)) begin
        word_nxt = right;
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    if (cmd.go) begin
      tap_r <= sel ? word_r : '0;
    end
  end

  assign word = word_r;
  assign tap  = tap_r;

endmodule
